@@ design/suid_pkg.sv @@
// ----------------------------------------------------------------------------
// suid_pkg: shared types for the set union / intersection / difference block
// Item kinds, controller states and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package suid_pkg;

  // Default number of elements per store
  localparam int unsigned DefCapacity = 8;

  // Field widths
  localparam int unsigned KindWidth  = 3;
  localparam int unsigned ValueWidth = 32;

  // Item kinds
  typedef enum logic [KindWidth-1:0] {
    KIND_CLEAR = 3'd0,
    KIND_ADD_A = 3'd1,
    KIND_ADD_B = 3'd2,
    KIND_UNION = 3'd3,
    KIND_INTER = 3'd4,
    KIND_DIFF  = 3'd5
  } kind_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UNI_A,
    ST_UNI_B,
    ST_INTER,
    ST_DIFF,
    ST_FLUSH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clear;   // empty both stores
    logic load_a;  // append the input value to A
    logic load_b;  // append the input value to B
    logic clr_i;
    logic inc_i;
    logic clr_j;
    logic inc_j;
    logic push;    // emit the current candidate
    logic sel_b;   // candidate is B[j] rather than A[i]
    logic flush;   // close the list
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic eq;          // A[i] equals B[j]
    logic i_last;      // i addresses the last element of A
    logic j_last;      // j addresses the last element of B
    logic na_zero;
    logic nb_zero;
    logic pend_valid;  // a candidate waits in the look-ahead slot
    logic out_free;    // output register can take a word this cycle
  } status_t;

endpackage

@@ design/suid_ctrl.sv @@
// ----------------------------------------------------------------------------
// suid_ctrl: sequencer for the set operations
// Decodes accepted items and walks the index pairs of the stores, one
// comparison per cycle, stalling whenever an emitted word has nowhere to go.
// ----------------------------------------------------------------------------
module suid_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [suid_pkg::KindWidth-1:0]      kind_i,
  input  suid_pkg::status_t                   status_i,
  output suid_pkg::cmd_t                      cmd_o
);
  import suid_pkg::*;

  state_e state_q, state_d;
  logic   can_push;
  logic   reject_b;  // union: B[j] found in A
  logic   reject_a;  // difference: A[i] found in B
  logic   end_b;     // union: B[j] survived the whole of A
  logic   end_a;     // difference: A[i] survived the whole of B

  assign can_push = !status_i.pend_valid || status_i.out_free;
  assign reject_b = !status_i.na_zero && status_i.eq;
  assign end_b    = status_i.na_zero || status_i.i_last;
  assign reject_a = !status_i.nb_zero && status_i.eq;
  assign end_a    = status_i.nb_zero || status_i.j_last;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            KIND_UNION: begin
              if (!status_i.na_zero)      state_d = ST_UNI_A;
              else if (!status_i.nb_zero) state_d = ST_UNI_B;
              else                        state_d = ST_FLUSH;
            end
            KIND_INTER: begin
              if (status_i.na_zero || status_i.nb_zero) state_d = ST_FLUSH;
              else                                      state_d = ST_INTER;
            end
            KIND_DIFF: begin
              if (status_i.na_zero) state_d = ST_FLUSH;
              else                  state_d = ST_DIFF;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_UNI_A: begin
        if (can_push && status_i.i_last) begin
          state_d = status_i.nb_zero ? ST_FLUSH : ST_UNI_B;
        end
      end
      ST_UNI_B: begin
        if (reject_b) begin
          if (status_i.j_last) state_d = ST_FLUSH;
        end else if (end_b && can_push && status_i.j_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_INTER: begin
        if ((!status_i.eq || can_push) && status_i.j_last && status_i.i_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_DIFF: begin
        if (reject_a) begin
          if (status_i.i_last) state_d = ST_FLUSH;
        end else if (end_a && can_push && status_i.i_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            KIND_CLEAR: cmd_o.clear  = 1'b1;
            KIND_ADD_A: cmd_o.load_a = 1'b1;
            KIND_ADD_B: cmd_o.load_b = 1'b1;
            KIND_UNION, KIND_INTER, KIND_DIFF: begin
              cmd_o.clr_i = 1'b1;
              cmd_o.clr_j = 1'b1;
            end
            default: cmd_o = '0;
          endcase
        end
      end
      ST_UNI_A: begin
        // every element of A goes out in order
        if (can_push) begin
          cmd_o.push = 1'b1;
          if (status_i.i_last) cmd_o.clr_i = 1'b1;
          else                 cmd_o.inc_i = 1'b1;
        end
      end
      ST_UNI_B: begin
        if (reject_b) begin
          cmd_o.clr_i = 1'b1;
          cmd_o.inc_j = 1'b1;
        end else if (end_b) begin
          if (can_push) begin
            cmd_o.push  = 1'b1;
            cmd_o.sel_b = 1'b1;
            cmd_o.clr_i = 1'b1;
            cmd_o.inc_j = 1'b1;
          end
        end else begin
          cmd_o.inc_i = 1'b1;
        end
      end
      ST_INTER: begin
        // emit A[i] for every matching B[j]
        if (!status_i.eq || can_push) begin
          cmd_o.push = status_i.eq;
          if (status_i.j_last) begin
            cmd_o.clr_j = 1'b1;
            cmd_o.inc_i = 1'b1;
          end else begin
            cmd_o.inc_j = 1'b1;
          end
        end
      end
      ST_DIFF: begin
        if (reject_a) begin
          cmd_o.clr_j = 1'b1;
          cmd_o.inc_i = 1'b1;
        end else if (end_a) begin
          if (can_push) begin
            cmd_o.push  = 1'b1;
            cmd_o.clr_j = 1'b1;
            cmd_o.inc_i = 1'b1;
          end
        end else begin
          cmd_o.inc_j = 1'b1;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush = status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/suid_dp.sv @@
// ----------------------------------------------------------------------------
// suid_dp: stores, scan indexes and output stage
// Holds both element stores and their counts, compares A[i] with B[j], and
// keeps one candidate in a look-ahead slot so the final word can carry last.
// ----------------------------------------------------------------------------
module suid_dp #(
  parameter int unsigned CAPACITY = suid_pkg::DefCapacity
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  suid_pkg::cmd_t                       cmd_i,
  output suid_pkg::status_t                    status_o,
  input  logic signed [suid_pkg::ValueWidth-1:0] value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [suid_pkg::ValueWidth-1:0] element_o,
  output logic                                 empty_res_o,
  output logic                                 last_o
);
  import suid_pkg::*;

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] Full = CW'(CAPACITY);

  logic [ValueWidth-1:0] store_a_q [CAPACITY];
  logic [ValueWidth-1:0] store_b_q [CAPACITY];
  logic [CW-1:0]         count_a_q, count_a_d;
  logic [CW-1:0]         count_b_q, count_b_d;
  logic [IW-1:0]         i_q, i_d;
  logic [IW-1:0]         j_q, j_d;
  logic [ValueWidth-1:0] elem_a, elem_b, cand;
  logic                  write_a, write_b;

  logic                  pend_valid_q, pend_valid_d;
  logic [ValueWidth-1:0] pend_q;
  logic                  out_valid_q, out_valid_d;
  logic [ValueWidth-1:0] out_elem_q;
  logic                  out_empty_q, out_last_q;
  logic                  out_free;
  logic                  to_out;

  assign elem_a = store_a_q[i_q];
  assign elem_b = store_b_q[j_q];
  assign cand   = cmd_i.sel_b ? elem_b : elem_a;

  assign write_a = cmd_i.load_a && (count_a_q != Full);
  assign write_b = cmd_i.load_b && (count_b_q != Full);

  assign out_free = !out_valid_q || out_ready_i;
  // a word moves to the output on a push behind a pending one, or on flush
  assign to_out   = (cmd_i.push && pend_valid_q) || cmd_i.flush;

  // Status
  always_comb begin
    status_o.eq         = (elem_a == elem_b);
    status_o.i_last     = ((CW'(i_q) + CW'(1)) == count_a_q);
    status_o.j_last     = ((CW'(j_q) + CW'(1)) == count_b_q);
    status_o.na_zero    = (count_a_q == '0);
    status_o.nb_zero    = (count_b_q == '0);
    status_o.pend_valid = pend_valid_q;
    status_o.out_free   = out_free;
  end

  // Counts and scan indexes
  always_comb begin
    count_a_d = count_a_q;
    count_b_d = count_b_q;
    if (cmd_i.clear) begin
      count_a_d = '0;
      count_b_d = '0;
    end
    if (write_a) count_a_d = count_a_q + CW'(1);
    if (write_b) count_b_d = count_b_q + CW'(1);

    i_d = i_q;
    if (cmd_i.clr_i)      i_d = '0;
    else if (cmd_i.inc_i) i_d = i_q + IW'(1);
    j_d = j_q;
    if (cmd_i.clr_j)      j_d = '0;
    else if (cmd_i.inc_j) j_d = j_q + IW'(1);
  end

  // Look-ahead slot and output valid
  always_comb begin
    pend_valid_d = pend_valid_q;
    if (cmd_i.push)  pend_valid_d = 1'b1;
    if (cmd_i.flush) pend_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (to_out)           out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_a_q    <= '0;
      count_b_q    <= '0;
      i_q          <= '0;
      j_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_a_q    <= count_a_d;
      count_b_q    <= count_b_d;
      i_q          <= i_d;
      j_q          <= j_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Stores and payload, no reset
  always_ff @(posedge clk_i) begin
    if (write_a) store_a_q[count_a_q[IW-1:0]] <= value_i;
    if (write_b) store_b_q[count_b_q[IW-1:0]] <= value_i;
    if (cmd_i.push) pend_q <= cand;
    if (cmd_i.flush) begin
      out_elem_q  <= pend_valid_q ? pend_q : '0;
      out_empty_q <= !pend_valid_q;
      out_last_q  <= 1'b1;
    end else if (to_out) begin
      out_elem_q  <= pend_q;
      out_empty_q <= 1'b0;
      out_last_q  <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign element_o   = out_elem_q;
  assign empty_res_o = out_empty_q;
  assign last_o      = out_last_q;

  // Counts never pass the capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_a_q <= Full) && (count_b_q <= Full))
    else $error("store count beyond capacity");

  // A word never moves to the output while the output is still occupied
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    to_out |-> out_free)
    else $error("output word overwritten");

  // An empty result always closes its list
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |-> out_last_q)
    else $error("empty result without last");

  // Flush always leaves the look-ahead slot empty
  a_flush_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> !pend_valid_q)
    else $error("candidate left behind after flush");

endmodule

@@ design/set_union_intersect_diff.sv @@
// Clear and add words are accepted in the controller's idle state. Emit words
// are accepted there too, then make one comparison per cycle, stalling when a
// word to emit has nowhere to go: union up to na + nb*max(na,1), intersection
// na*nb, difference up to na*max(nb,1); the flush state then closes the list
// and the last word is registered in the output stage.
// Reset clears both counts and the output stage; store contents are undefined.
// ----------------------------------------------------------------------------
// set_union_intersect_diff: set union, intersection and difference engine
// Loads two small element stores and streams the requested list on demand.
// ----------------------------------------------------------------------------
module set_union_intersect_diff #(
  parameter int unsigned CAPACITY = suid_pkg::DefCapacity
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [suid_pkg::KindWidth-1:0]         kind_i,
  input  logic signed [suid_pkg::ValueWidth-1:0] value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [suid_pkg::ValueWidth-1:0] element_o,
  output logic                                   empty_res_o,
  output logic                                   last_o
);
  import suid_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  suid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Stores, compare and output stage
  suid_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .element_o   (element_o),
    .empty_res_o (empty_res_o),
    .last_o      (last_o)
  );

endmodule

@@ verif/set_union_intersect_diff_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_union_intersect_diff_test: regression for the set list engine
// Loads sets A and B through the input channel, requests union, intersection
// and difference lists, and checks every streamed word against a model of
// the two stores kept in a scoreboard. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module set_union_intersect_diff_test;
  import suid_pkg::*;

  localparam int unsigned Capacity       = DefCapacity;
  localparam int unsigned ItemTarget     = 320;
  localparam int unsigned EmitLatency    = Capacity * Capacity + Capacity + 2;
  localparam int unsigned TailCycles     = 4 * EmitLatency;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned MaxReports     = 10;
  localparam int unsigned TimeLimitNs    = 10_000_000;

  // Kind codes the block must ignore
  localparam logic [KindWidth-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KindWidth-1:0] KIND_SPARE_HI = 3'd7;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [KindWidth-1:0]         kind_i;
  logic signed [ValueWidth-1:0] value_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic signed [ValueWidth-1:0] element_o;
  logic                         empty_res_o;
  logic                         last_o;

  // --------------------------------------------------------------------------
  // Scoreboard: mirror of both stores and the queue of list words due
  // --------------------------------------------------------------------------
  class suid_scoreboard;
    typedef struct {
      logic [ValueWidth-1:0] element;
      logic                  empty_res;
      logic                  last;
    } list_word_t;

    logic [ValueWidth-1:0] set_a[Capacity];
    logic [ValueWidth-1:0] set_b[Capacity];
    int unsigned           len_a;
    int unsigned           len_b;
    list_word_t            list_q[$];
    int unsigned           faults;

    function new();
      len_a  = 0;
      len_b  = 0;
      faults = 0;
    endfunction

    function int unsigned pending_count();
      return list_q.size();
    endfunction

    function bit in_a(logic [ValueWidth-1:0] v);
      for (int unsigned k = 0; k < len_a; k++) begin
        if (set_a[k] == v) return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit in_b(logic [ValueWidth-1:0] v);
      for (int unsigned k = 0; k < len_b; k++) begin
        if (set_b[k] == v) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void push_element(logic [ValueWidth-1:0] v);
      list_word_t w;
      w.element   = v;
      w.empty_res = 1'b0;
      w.last      = 1'b0;
      list_q.push_back(w);
    endfunction

    // Apply one accepted input word and queue the list it produces
    function void note_word(logic [KindWidth-1:0] kind, logic [ValueWidth-1:0] value);
      int unsigned first;
      list_word_t  w;
      first = list_q.size();
      case (kind)
        KIND_CLEAR: begin
          len_a = 0;
          len_b = 0;
          return;
        end
        KIND_ADD_A: begin
          if (len_a < Capacity) begin
            set_a[len_a] = value;
            len_a++;
          end
          return;
        end
        KIND_ADD_B: begin
          if (len_b < Capacity) begin
            set_b[len_b] = value;
            len_b++;
          end
          return;
        end
        KIND_UNION: begin
          for (int unsigned i = 0; i < len_a; i++) push_element(set_a[i]);
          for (int unsigned j = 0; j < len_b; j++) begin
            if (!in_a(set_b[j])) push_element(set_b[j]);
          end
        end
        KIND_INTER: begin
          for (int unsigned i = 0; i < len_a; i++) begin
            for (int unsigned j = 0; j < len_b; j++) begin
              if (set_a[i] == set_b[j]) push_element(set_a[i]);
            end
          end
        end
        KIND_DIFF: begin
          for (int unsigned i = 0; i < len_a; i++) begin
            if (!in_b(set_a[i])) push_element(set_a[i]);
          end
        end
        default: return;
      endcase
      // Close the list, or stand in one empty marker word
      if (list_q.size() == first) begin
        w.element   = '0;
        w.empty_res = 1'b1;
        w.last      = 1'b1;
        list_q.push_back(w);
      end else begin
        list_q[list_q.size() - 1].last = 1'b1;
      end
    endfunction

    // Compare one streamed word with the oldest word due
    function void check_result(logic [ValueWidth-1:0] element, logic empty_res, logic last);
      list_word_t w;
      if (list_q.size() == 0) begin
        faults++;
        if (faults <= MaxReports)
          $display("unexpected word: element %0d empty %b last %b",
                   $signed(element), empty_res, last);
        return;
      end
      w = list_q.pop_front();
      // An empty marker carries element zero
      if (w.empty_res !== empty_res || w.last !== last || w.element !== element) begin
        faults++;
        if (faults <= MaxReports)
          $display("word mismatch: want element %0d empty %b last %b, got %0d %b %b",
                   $signed(w.element), w.empty_res, w.last,
                   $signed(element), empty_res, last);
      end
    endfunction
  endclass

  suid_scoreboard board;
  int unsigned    burst_left;
  int unsigned    items_sent;
  bit             hold_off_req;

  set_union_intersect_diff #(
    .CAPACITY(Capacity)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .element_o  (element_o),
    .empty_res_o(empty_res_o),
    .last_o     (last_o)
  );

  // Clock: 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Observe both handshakes at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_word(kind_i, value_i);
      if (out_valid_o && out_ready_i) board.check_result(element_o, empty_res_o, last_o);
    end
  end

  // Receiver: random stall modes, plus one long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned run_left;
    int unsigned hold_left;
    bit          phase;
    mode      = 0;
    run_left  = 0;
    hold_left = 0;
    phase     = 1'b0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = LongHoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 4);
          run_left = $urandom_range(8, 60);
        end
        run_left--;
        phase = ~phase;
        case (mode)
          1:       out_ready_i <= ($urandom_range(0, 3) != 0);
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          3:       out_ready_i <= phase;
          default: out_ready_i <= 1'b1;
        endcase
      end
    end
  end

  // Present one word and hold it until accepted
  task automatic send_word(input logic [KindWidth-1:0] kind, input logic [ValueWidth-1:0] value);
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic idle_input(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Send in bursts of random length with random gaps between them
  task automatic offer_word(input logic [KindWidth-1:0] kind, input logic [ValueWidth-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) idle_input(gap);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_word(kind, value);
    if (kind != KIND_SPARE_LO && kind != KIND_SPARE_HI) items_sent++;
  endtask

  // Pause the sender until every list word has come out
  task automatic drain_lists();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_count() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ValueWidth-1:0] pick_value(int unsigned pool,
                                                       logic [ValueWidth-1:0] base);
    case (pool)
      0:       return base + $urandom_range(0, 3);
      1:       return $urandom_range(0, 5);
      2:       return $urandom();
      default: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'hffff_ffff;
          3:       return 32'h0000_0001;
          default: return 32'h0000_0000;
        endcase
      end
    endcase
  endfunction

  // Load both sets with related values, then ask for a few lists
  task automatic load_and_emit();
    int unsigned           left_a;
    int unsigned           left_b;
    int unsigned           pool;
    int unsigned           n_emit;
    logic [ValueWidth-1:0] base;
    if ($urandom_range(0, 3) != 0) offer_word(KIND_CLEAR, $urandom());
    left_a = ($urandom_range(0, 7) == 0) ? $urandom_range(Capacity + 1, Capacity + 3)
                                         : $urandom_range(0, Capacity);
    left_b = ($urandom_range(0, 7) == 0) ? $urandom_range(Capacity + 1, Capacity + 3)
                                         : $urandom_range(0, Capacity);
    pool   = $urandom_range(0, 3);
    base   = $urandom();
    while (left_a + left_b != 0) begin
      if (left_b == 0 || (left_a != 0 && $urandom_range(0, 1) == 0)) begin
        offer_word(KIND_ADD_A, pick_value(pool, base));
        left_a--;
      end else begin
        offer_word(KIND_ADD_B, pick_value(pool, base));
        left_b--;
      end
    end
    n_emit = $urandom_range(1, 3);
    repeat (n_emit) offer_word(KindWidth'($urandom_range(KIND_UNION, KIND_DIFF)), $urandom());
  endtask

  // Main sequence
  initial begin
    int unsigned pick;
    board        = new();
    burst_left   = 0;
    items_sent   = 0;
    hold_off_req = 1'b0;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    kind_i       <= KIND_CLEAR;
    value_i      <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty lists, ignored kinds, extremes, duplicates, full stores
    offer_word(KIND_UNION, 32'h0);
    offer_word(KIND_INTER, 32'hffff_ffff);
    offer_word(KIND_DIFF, 32'h0);
    offer_word(KIND_SPARE_LO, 32'h1234_5678);
    offer_word(KIND_SPARE_HI, 32'hedcb_a987);
    offer_word(KIND_ADD_A, 32'h8000_0000);
    offer_word(KIND_ADD_A, 32'h7fff_ffff);
    offer_word(KIND_ADD_A, 32'hffff_ffff);
    offer_word(KIND_ADD_A, 32'h0000_0000);
    offer_word(KIND_ADD_A, 32'h7fff_ffff);
    offer_word(KIND_ADD_B, 32'h7fff_ffff);
    offer_word(KIND_ADD_B, 32'h0000_0005);
    offer_word(KIND_ADD_B, 32'h7fff_ffff);
    offer_word(KIND_UNION, 32'h0);
    offer_word(KIND_INTER, 32'h0);
    offer_word(KIND_DIFF, 32'h0);
    // Fill A and push one more past capacity
    for (int k = 0; k < 4; k++) offer_word(KIND_ADD_A, 32'h5555_aaaa + k);
    offer_word(KIND_DIFF, 32'h0);
    offer_word(KIND_CLEAR, 32'h0);
    offer_word(KIND_INTER, 32'h0);
    offer_word(KIND_ADD_B, 32'h1);
    offer_word(KIND_DIFF, 32'h0);
    drain_lists();

    // Long receiver hold-off while full-size intersections pile up
    hold_off_req = 1'b1;
    offer_word(KIND_CLEAR, 32'h0);
    for (int k = 0; k < Capacity; k++) offer_word(KIND_ADD_A, 32'h0000_0007);
    for (int k = 0; k < Capacity; k++) offer_word(KIND_ADD_B, 32'h0000_0007);
    offer_word(KIND_INTER, 32'h0);
    offer_word(KIND_UNION, 32'h0);
    offer_word(KIND_INTER, 32'h0);
    drain_lists();

    // Random: mostly load-and-emit sequences, some noise and pauses
    while (items_sent < ItemTarget) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        load_and_emit();
      end else if (pick < 9) begin
        repeat ($urandom_range(1, 3)) offer_word(KindWidth'($urandom_range(0, 7)), $urandom());
      end else begin
        drain_lists();
      end
    end

    drain_lists();
    repeat (TailCycles) @(posedge clk_i);
    if (board.faults == 0 && board.pending_count() == 0) begin
      $display("set_union_intersect_diff regression: pass");
    end else begin
      if (board.pending_count() != 0)
        $display("%0d list words never arrived", board.pending_count());
      $display("set_union_intersect_diff regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TimeLimitNs);
    $display("set_union_intersect_diff regression: fail");
    $finish;
  end

endmodule
